// ===== design/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded deque
// Operation codes, status codes and the bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned CapacityDef  = 64;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned CountWidth   = 7;

  // operation codes
  localparam logic [2:0] FuncPushFront = 3'd0;
  localparam logic [2:0] FuncPushBack  = 3'd1;
  localparam logic [2:0] FuncPopFront  = 3'd2;
  localparam logic [2:0] FuncPopBack   = 3'd3;
  localparam logic [2:0] FuncCount     = 3'd4;
  localparam logic [2:0] FuncErase     = 3'd5;

  // status codes
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusEmpty = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  // controller commands to the datapath
  typedef struct packed {
    logic load;       // capture operand and function
    logic push_head;
    logic push_tail;
    logic pop_head;
    logic pop_tail;
    logic scan_start; // clear scan pointers
    logic scan_rd;    // issue read of slot at scan pointer
    logic scan_eval;  // evaluate returned word
    logic scan_done;  // commit erase count
    logic ends_rd;    // read front and back words
    logic finish;     // present result
  } bdq_cmd_t;

  // datapath status back to controller
  typedef struct packed {
    logic [2:0] func;
    logic       empty;
    logic       full;
    logic       scan_last; // scan pointer reached count
  } bdq_stat_t;

endpackage

// ===== design/bdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl: operation sequencer
// Steps each transaction through its operation, scan loop and end readout.
// ----------------------------------------------------------------------------
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  bdq_stat_t stat_i,
  output bdq_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StExec  = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StEval  = 3'd3;
  localparam logic [2:0] StEnds  = 3'd4;
  localparam logic [2:0] StWait  = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0] state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        unique case (stat_i.func)
          FuncPushFront: begin
            cmd_o.push_head = !stat_i.full;
            state_d         = StEnds;
          end
          FuncPushBack: begin
            cmd_o.push_tail = !stat_i.full;
            state_d         = StEnds;
          end
          FuncPopFront: begin
            cmd_o.pop_head = !stat_i.empty;
            state_d        = StEnds;
          end
          FuncPopBack: begin
            cmd_o.pop_tail = !stat_i.empty;
            state_d        = StEnds;
          end
          FuncCount, FuncErase: begin
            cmd_o.scan_start = 1'b1;
            state_d          = StScan;
          end
          default: state_d = StEnds;
        endcase
      end
      StScan: begin
        if (stat_i.scan_last) begin
          cmd_o.scan_done = 1'b1;
          state_d         = StEnds;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = StEval;
        end
      end
      StEval: begin
        cmd_o.scan_eval = 1'b1;
        state_d         = StScan;
      end
      StEnds: begin
        cmd_o.ends_rd = 1'b1;
        state_d       = StWait;
      end
      StWait: state_d = StDone;
      StDone: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  property p_load_only_idle;
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.load |-> !busy_o;
  endproperty
  a_load_only_idle: assert property (p_load_only_idle) else $error("load while busy");

  property p_eval_follows_rd;
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.scan_rd |=> cmd_o.scan_eval;
  endproperty
  a_eval_follows_rd: assert property (p_eval_follows_rd) else $error("eval lost");

  property p_finish_after_ends;
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.ends_rd |=> ##1 cmd_o.finish;
  endproperty
  a_finish_after_ends: assert property (p_finish_after_ends) else $error("no finish");

endmodule

// ===== design/bdq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_dp: deque datapath
// Circular entry store, head and count registers, scan/compact logic, result.
// ----------------------------------------------------------------------------
module bdq_dp
  import bdq_pkg::*;
#(
  parameter int unsigned Capacity  = CapacityDef,
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdq_cmd_t              cmd_i,
  output bdq_stat_t             stat_o,
  input  logic [2:0]            func_i,
  input  logic [DataWidth-1:0]  operand_value_i,
  output logic                  done_o,
  output logic [FieldWidth-1:0] popped_value_o,
  output logic [CountWidth-1:0] match_count_o,
  output logic [CountWidth-1:0] occupancy_o,
  output logic [FieldWidth-1:0] front_value_o,
  output logic [FieldWidth-1:0] back_value_o,
  output logic [1:0]            status_o
);

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam logic [AW:0] CapM1 = (AW + 1)'(Capacity - 1);

  logic [DataWidth-1:0] mem_q [Capacity];
  logic [DataWidth-1:0] rd_a_q, rd_b_q;

  logic [2:0]           func_q;
  logic [DataWidth-1:0] opv_q;
  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        rd_i_q, kept_q, match_q;
  logic [FieldWidth-1:0] pop_q;
  logic [1:0]           stat_q;
  logic                 pop_pend_q, done_q;

  // slot = (head + off) mod capacity, off < capacity
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [AW+1:0] s;
    s = (AW + 2)'(h) + (AW + 2)'(off);
    if (s > (AW + 2)'(CapM1)) s = s - (AW + 2)'(Capacity);
    return s[AW-1:0];
  endfunction

  function automatic logic [FieldWidth-1:0] fext(input logic [DataWidth-1:0] v);
    return FieldWidth'($signed(v));
  endfunction

  logic          full, empty;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] wr_a;
  logic [DataWidth-1:0] wr_v;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] ra, rb;
  logic          push_in, pop_in;

  assign full  = (cnt_q >= CW'(Capacity));
  assign empty = (cnt_q == '0);
  assign head_dec = (head_q == '0) ? AW'(Capacity - 1) : head_q - AW'(1);

  assign stat_o.func      = func_q;
  assign stat_o.empty     = empty;
  assign stat_o.full      = full;
  assign stat_o.scan_last = (rd_i_q == cnt_q);

  // write port select; only erase moves entries down
  always_comb begin
    wr_en = 1'b0;
    wr_a  = slot(head_q, cnt_q);
    wr_v  = opv_q;
    if (cmd_i.push_head) begin
      wr_en = 1'b1;
      wr_a  = head_dec;
    end else if (cmd_i.push_tail) begin
      wr_en = 1'b1;
    end else if (cmd_i.scan_eval && (func_q == FuncErase) && (rd_a_q != opv_q)) begin
      wr_en = 1'b1;
      wr_a  = slot(head_q, kept_q);
      wr_v  = rd_a_q;
    end
  end

  // read addresses: front pop and scan use port a, back pop uses port b, ends use both
  always_comb begin
    ra = head_q;
    rb = slot(head_q, cnt_q - CW'(1));
    if (cmd_i.scan_rd) ra = slot(head_q, rd_i_q);
  end

  assign rd_en = cmd_i.pop_head || cmd_i.pop_tail || cmd_i.scan_rd || cmd_i.ends_rd;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_a] <= wr_v;
    if (rd_en) begin
      rd_a_q <= mem_q[ra];
      rd_b_q <= mem_q[rb];
    end
  end

  // head and count
  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    if (cmd_i.push_head) begin
      head_d = head_dec;
      cnt_d  = cnt_q + CW'(1);
    end else if (cmd_i.push_tail) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.pop_head) begin
      head_d = slot(head_q, CW'(1));
      cnt_d  = cnt_q - CW'(1);
    end else if (cmd_i.pop_tail) begin
      cnt_d = cnt_q - CW'(1);
    end else if (cmd_i.scan_done && (func_q == FuncErase)) begin
      cnt_d = kept_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      cnt_q      <= '0;
      done_q     <= 1'b0;
      pop_pend_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      done_q     <= cmd_i.finish;
      pop_pend_q <= cmd_i.pop_head || cmd_i.pop_tail;
    end
  end

  // transaction payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      opv_q  <= operand_value_i;
    end
  end

  // refused push or pop is known at load, queue state is stable until then
  assign push_in = (func_i == FuncPushFront) || (func_i == FuncPushBack);
  assign pop_in  = (func_i == FuncPopFront) || (func_i == FuncPopBack);

  // status and popped word; the popped word passes through the read register, then into pop_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (push_in && full) begin
        stat_q <= StatusFull;
        pop_q  <= '0;
      end else if (pop_in && empty) begin
        stat_q <= StatusEmpty;
        pop_q  <= '1;
      end else begin
        stat_q <= StatusOk;
        pop_q  <= '0;
      end
    end else if (pop_pend_q) begin
      pop_q <= (func_q == FuncPopFront) ? fext(rd_a_q) : fext(rd_b_q);
    end
  end

  // scan pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      rd_i_q <= '0;
      kept_q <= '0;
    end else begin
      if (cmd_i.scan_rd) rd_i_q <= rd_i_q + CW'(1);
      if (cmd_i.scan_eval && (rd_a_q != opv_q)) kept_q <= kept_q + CW'(1);
    end
  end

  // match counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      match_q <= '0;
    end else if (cmd_i.scan_eval && (rd_a_q == opv_q)) begin
      match_q <= match_q + CW'(1);
    end
  end

  // result outputs
  assign done_o         = done_q;
  assign popped_value_o = pop_q;
  assign match_count_o  = CountWidth'(match_q);
  assign occupancy_o    = CountWidth'(cnt_q);
  assign front_value_o  = empty ? '1 : fext(rd_a_q);
  assign back_value_o   = empty ? '1 : fext(rd_b_q);
  assign status_o       = stat_q;

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(Capacity);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("count over capacity");

  property p_kept_le_read;
    @(posedge clk_i) disable iff (!rst_ni) cmd_i.scan_done |-> kept_q <= rd_i_q;
  endproperty
  a_kept_le_read: assert property (p_kept_le_read) else $error("compaction overrun");

  property p_push_grows;
    @(posedge clk_i) disable iff (!rst_ni) cmd_i.push_tail |=> cnt_q == $past(cnt_q) + CW'(1);
  endproperty
  a_push_grows: assert property (p_push_grows) else $error("push count");

endmodule

// ===== design/bounded_deque_with_erase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_erase: bounded double-ended queue with count and erase
// Command-style wrapper around the sequencer and the deque datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with func_i and operand_value_i while busy is low; the
//   transaction is taken at that edge and busy rises the next cycle.
//   Exactly one result follows, shown for one cycle with done_o high:
//   popped_value_o, match_count_o, occupancy_o, front_value_o, back_value_o
//   and status_o. The receiver cannot stall; the result is gone after that.
// Sequencing:
//   push, pop and unused codes pass from the operation step straight to the
//   end readout and then raise done_o. count and erase scan the stored
//   entries before the end readout; the scan reads each entry into a register
//   (StScan), then compares and writes it back (StEval), and erase compacts in place as it goes.
//   busy drops together with done_o, so the next transaction can be taken
//   at the edge that ends the done_o cycle.
// Reset:
//   rst_ni clears the head pointer and entry count (empty queue) and the
//   sequencer. Memory contents are not cleared; unwritten slots never reach the outputs.
// ----------------------------------------------------------------------------
module bounded_deque_with_erase
  import bdq_pkg::*;
#(
  parameter int unsigned Capacity  = CapacityDef,
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            func_i,
  input  logic signed [31:0]    operand_value_i,
  output logic                  done_o,
  output logic signed [31:0]    popped_value_o,
  output logic [6:0]            match_count_o,
  output logic [6:0]            occupancy_o,
  output logic signed [31:0]    front_value_o,
  output logic signed [31:0]    back_value_o,
  output logic [1:0]            status_o
);

  bdq_cmd_t  cmd;
  bdq_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  bdq_dp #(
    .Capacity (Capacity),
    .DataWidth(DataWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .operand_value_i(DataWidth'(operand_value_i)),
    .done_o         (done_o),
    .popped_value_o (popped_value_o),
    .match_count_o  (match_count_o),
    .occupancy_o    (occupancy_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .status_o       (status_o)
  );

endmodule

// ===== bench/tb_bounded_deque_with_erase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_erase: self-checking bench for the bounded deque
// Drives directed tests (empty pops, full pushes, extreme values, every
// operation, erase of adjacent matches) and then random traffic biased to
// keep the queue busy. A behavioral deque predicts each result; results are
// compared field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_erase;
  import bdq_pkg::*;

  localparam int Depth = 64;

  // unused operation codes
  localparam logic [2:0] FuncSpareA = 3'd6;
  localparam logic [2:0] FuncSpareB = 3'd7;

  typedef struct packed {
    logic signed [31:0] popped;
    logic [6:0]         hits;
    logic [6:0]         occ;
    logic signed [31:0] front;
    logic signed [31:0] back;
    logic [1:0]         status;
  } deque_res_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] val;
    logic               known;  // expected result typed in the table
    deque_res_t         res;
  } table_row_t;

  logic clk_i, rst_ni, start, busy, done_o;
  logic [2:0] func_i;
  logic signed [31:0] operand_value_i;
  logic signed [31:0] popped_value_o, front_value_o, back_value_o;
  logic [6:0] match_count_o, occupancy_o;
  logic [1:0] status_o;

  bounded_deque_with_erase dut (.*);

  // shadow deque contents, front at index 0
  logic signed [31:0] shadow_q[$];
  deque_res_t pending_q[$];
  int errors;
  int n_sent, n_checked;
  bit quiet;  // no idling in this stretch

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  // next state and result of the deque for one transaction
  function automatic deque_res_t deque_apply(input logic [2:0] op,
                                             input logic signed [31:0] v);
    deque_res_t r;
    logic signed [31:0] kept[$];
    r = '0;
    case (op)
      FuncPushFront: if (shadow_q.size() >= Depth) r.status = StatusFull;
                     else shadow_q.insert(0, v);
      FuncPushBack:  if (shadow_q.size() >= Depth) r.status = StatusFull;
                     else shadow_q.push_back(v);
      FuncPopFront: begin
        if (shadow_q.size() == 0) begin
          r.status = StatusEmpty;
          r.popped = -1;
        end else begin
          r.popped = shadow_q[0];
          shadow_q.delete(0);
        end
      end
      FuncPopBack: begin
        if (shadow_q.size() == 0) begin
          r.status = StatusEmpty;
          r.popped = -1;
        end else r.popped = shadow_q.pop_back();
      end
      FuncCount: foreach (shadow_q[i]) if (shadow_q[i] == v) r.hits++;
      FuncErase: begin
        foreach (shadow_q[i]) begin
          if (shadow_q[i] == v) r.hits++;
          else kept.push_back(shadow_q[i]);
        end
        shadow_q = kept;
      end
      default: ;
    endcase
    r.occ = 7'(shadow_q.size());
    r.front = shadow_q.size() ? shadow_q[0] : -1;
    r.back = shadow_q.size() ? shadow_q[$] : -1;
    return r;
  endfunction

  // send one transaction; random idle before it unless quiet
  task automatic send_op(input logic [2:0] op, input logic signed [31:0] v,
                         input bit known, input deque_res_t want);
    deque_res_t pred;
    while (!quiet && $urandom_range(99) < 13) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= op;
    operand_value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = deque_apply(op, v);
    if (known && pred !== want) begin
      $display("table row %0d disagrees with prediction", n_sent);
      errors++;
    end
    pending_q.push_back(known ? want : pred);
    n_sent++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("unexpected result");
        errors++;
      end else begin
        deque_res_t w;
        w = pending_q[0];
        pending_q.delete(0);
        if (popped_value_o !== w.popped) report_mismatch("popped", popped_value_o, w.popped);
        if (match_count_o !== w.hits)
          report_mismatch("matched", 32'(match_count_o), 32'(w.hits));
        if (occupancy_o !== w.occ)
          report_mismatch("occupancy", 32'(occupancy_o), 32'(w.occ));
        if (front_value_o !== w.front) report_mismatch("front", front_value_o, w.front);
        if (back_value_o !== w.back) report_mismatch("back", back_value_o, w.back);
        if (status_o !== w.status)
          report_mismatch("status", 32'(status_o), 32'(w.status));
      end
      n_checked++;
    end
  end

  function automatic table_row_t row(input logic [2:0] op, input logic signed [31:0] v);
    row = '{op: op, val: v, known: 1'b0, res: '0};
  endfunction

  function automatic table_row_t row_k(input logic [2:0] op, input logic signed [31:0] v,
                                       input deque_res_t r);
    row_k = '{op: op, val: v, known: 1'b1, res: r};
  endfunction

  // pick an operand: mostly from a small pool so hits happen
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return -1;
      default: return $urandom_range(4);
    endcase
  endfunction

  initial begin
    table_row_t dir[$];
    logic [2:0] op;
    int k, lim, fill;
    errors = 0; n_sent = 0; n_checked = 0; quiet = 0;
    rst_ni = 1'b0; start = 1'b0; func_i = '0; operand_value_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pops, extremes, unused codes, adjacent-match erase
    dir.push_back(row_k(FuncPopFront, 0, '{-1, 0, 0, -1, -1, StatusEmpty}));
    dir.push_back(row_k(FuncPopBack, 0, '{-1, 0, 0, -1, -1, StatusEmpty}));
    dir.push_back(row_k(FuncCount, 5, '{0, 0, 0, -1, -1, StatusOk}));
    dir.push_back(row_k(FuncErase, 5, '{0, 0, 0, -1, -1, StatusOk}));
    dir.push_back(row_k(FuncSpareA, 0, '{0, 0, 0, -1, -1, StatusOk}));
    dir.push_back(row_k(FuncPushBack, 32'sh7fffffff,
                        '{0, 0, 1, 32'sh7fffffff, 32'sh7fffffff, StatusOk}));
    dir.push_back(row_k(FuncPushFront, 32'sh80000000,
                        '{0, 0, 2, 32'sh80000000, 32'sh7fffffff, StatusOk}));
    dir.push_back(row(FuncPushBack, 7));
    dir.push_back(row(FuncPushBack, 7));
    dir.push_back(row(FuncPushBack, 7));
    dir.push_back(row(FuncPushBack, -1));
    dir.push_back(row(FuncPushFront, 7));
    dir.push_back(row(FuncSpareB, 32'shffffffff));
    dir.push_back(row(FuncCount, 7));
    dir.push_back(row(FuncErase, 7));
    dir.push_back(row(FuncCount, -1));
    dir.push_back(row(FuncPopBack, 0));
    dir.push_back(row(FuncPopFront, 0));
    dir.push_back(row(FuncErase, 32'sh80000000));
    dir.push_back(row(FuncPopFront, 0));
    foreach (dir[i]) send_op(dir[i].op, dir[i].val, dir[i].known, dir[i].res);

    // fill to capacity, then overflow at both ends
    for (k = 0; k < Depth; k++) send_op(FuncPushBack, k % 3, 0, '0);
    send_op(FuncPushFront, 1, 1, '{0, 0, 64, 0, 0, StatusFull});
    send_op(FuncPushBack, 1, 1, '{0, 0, 64, 0, 0, StatusFull});
    send_op(FuncCount, 0, 0, '0);
    send_op(FuncErase, 1, 0, '0);

    // hold off until every expected result has arrived
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);

    // random traffic; push bias alternates so the queue fills and drains
    fill = 1;
    for (k = 0; k < 1000; k++) begin
      quiet = (k >= 400 && k < 550);
      if (k % 150 == 0) fill = !fill;
      lim = $urandom_range(99);
      if (lim < 6) op = $urandom_range(1) ? FuncSpareB : FuncSpareA;
      else if (lim < 50) op = fill ? ($urandom_range(1) ? FuncPushBack : FuncPushFront)
                                   : ($urandom_range(1) ? FuncPopBack : FuncPopFront);
      else if (lim < 70) op = 3'($urandom_range(3));
      else if (lim < 85) op = FuncCount;
      else op = FuncErase;
      send_op(op, pick_value(), 0, '0);
    end
    start <= 1'b0;

    lim = 0;
    while (pending_q.size() != 0 && lim < 100000) begin
      @(posedge clk_i);
      lim++;
    end
    repeat (150) @(posedge clk_i);
    $display("sent %0d transactions, checked %0d results,", n_sent, n_checked);
    $display("covering empty and full ends, all operations and erase of runs");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bdq_pkg.sv
design/bdq_ctrl.sv
design/bdq_dp.sv
design/bounded_deque_with_erase.sv
bench/tb_bounded_deque_with_erase.sv
